>>> design/scd_pkg.sv
`default_nettype none
package scd_pkg;

  // Fixed-point and sizing constants.
  localparam int FRAC_BITS = 16;
  localparam int TWO_F     = 2 * FRAC_BITS;
  localparam int IN_W      = 12;
  localparam int ACC_W     = 36;
  localparam int SQS_W     = 60;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int REM_W     = PROD_W + 1;
  localparam int HALF_W    = ACC_W / 2;
  localparam int RES_W     = FRAC_BITS + 1;
  localparam int OUT_W     = 17;
  localparam int CNT_W     = $clog2(TWO_F + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // One finished set of sums, moved from the front to the back.
  typedef struct packed {
    logic [ACC_W-1:0] energy_a;
    logic [ACC_W-1:0] energy_b;
    logic [ACC_W-1:0] shared_dot;
    logic [SQS_W-1:0] shared_square_sum;
  } sums_t;

  // Saturating accumulate at the accumulator width.
  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] v);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  function automatic logic [SQS_W-1:0] sat_sqs(input logic [SQS_W-1:0] acc,
                                               input logic [SQS_W-1:0] v);
    logic [SQS_W:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[SQS_W] ? {SQS_W{1'b1}} : s[SQS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/scd_front.sv
`default_nettype none
module scd_front import scd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [IN_W-1:0] bin_a,
  input  wire logic [IN_W-1:0] bin_b,
  input  wire logic            last_bin,
  input  wire logic [Q_CNT_W-1:0] q_count,
  output logic                 push,
  output sums_t                push_data
);

  logic                v1, last1, both1;
  logic [2*IN_W-1:0]   aa, bb, ab;
  logic                v2, last2, both2;
  logic [4*IN_W-1:0]   pp;
  logic [ACC_W-1:0]    energy_a, energy_b, shared_dot;
  logic [ACC_W-1:0]    ea_next, eb_next, dot_next;
  logic [ACC_W-1:0]    hold_ea, hold_eb, hold_dot;
  logic [SQS_W-1:0]    shared_square_sum, sqs_next;
  logic [Q_CNT_W:0]    credit;
  logic                accept;

  // Items holding a last beat in flight count against the queue space.
  assign credit = {1'b0, q_count} + (Q_CNT_W+1)'(v1 & last1) + (Q_CNT_W+1)'(v2 & last2);
  assign in_ready = credit < (Q_CNT_W+1)'(Q_DEPTH);
  assign accept = in_valid & in_ready;

  // Stage one registers the three products of the pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    last1 <= last_bin;
    both1 <= (bin_a != '0) && (bin_b != '0);
    aa <= bin_a * bin_a;
    bb <= bin_b * bin_b;
    ab <= bin_a * bin_b;
  end

  assign ea_next  = sat_acc(energy_a, ACC_W'(aa));
  assign eb_next  = sat_acc(energy_b, ACC_W'(bb));
  assign dot_next = both1 ? sat_acc(shared_dot, ACC_W'(ab)) : shared_dot;

  // Stage two accumulates the narrow sums and squares the shared product.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      energy_a <= '0;
      energy_b <= '0;
      shared_dot <= '0;
    end else begin
      v2 <= v1;
      if (v1) begin
        if (last1) begin
          energy_a <= '0;
          energy_b <= '0;
          shared_dot <= '0;
        end else begin
          energy_a <= ea_next;
          energy_b <= eb_next;
          shared_dot <= dot_next;
        end
      end
    end
    if (v1 && last1) begin
      hold_ea <= ea_next;
      hold_eb <= eb_next;
      hold_dot <= dot_next;
    end
    last2 <= last1;
    both2 <= both1;
    pp <= ab * ab;
  end

  assign sqs_next = both2 ? sat_sqs(shared_square_sum, SQS_W'(pp)) : shared_square_sum;

  // Stage three accumulates the wide sum and hands the set to the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_square_sum <= '0;
    end else if (v2) begin
      shared_square_sum <= last2 ? '0 : sqs_next;
    end
  end

  assign push = v2 & last2;
  assign push_data.energy_a = hold_ea;
  assign push_data.energy_b = hold_eb;
  assign push_data.shared_dot = hold_dot;
  assign push_data.shared_square_sum = sqs_next;

endmodule
`default_nettype wire

>>> design/scd_queue.sv
`default_nettype none
module scd_queue import scd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire sums_t push_data,
  input  wire logic  pop,
  output logic       q_valid,
  output sums_t      q_data,
  output logic [Q_CNT_W-1:0] q_count
);

  sums_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr, rd;

  assign q_valid = q_count != '0;
  assign q_data = mem[rd];

  // Small register queue; the front never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      q_count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      q_count <= q_count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
    if (push) mem[wr] <= push_data;
  end

endmodule
`default_nettype wire

>>> design/scd_back.sv
`default_nettype none
module scd_back import scd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire sums_t q_data,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [OUT_W-1:0] similarity,
  output logic [OUT_W-1:0] bias,
  output logic       undefined
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DSET = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQRT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic               phase, und;
  logic [ACC_W-1:0]   m_ea, m_eb, m_dot;
  logic [SQS_W-1:0]   sqs;
  logic [PROD_W-1:0]  dsq, eprod;
  logic [REM_W-1:0]   rem, rem_sh;
  logic [TWO_F-1:0]   quo, sres, sbit, strial, sres_next;
  logic [RES_W-1:0]   sim_hold, bias_hold;
  logic [ACC_W-1:0]   mul_x;
  logic [HALF_W-1:0]  mul_y;
  logic [ACC_W+HALF_W-1:0] mul_p;
  logic [PROD_W-1:0]  num_sel, den_sel;

  // One shared 36 by 18 multiplier builds both wide products in halves.
  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin mul_x = m_dot; mul_y = m_dot[HALF_W-1:0]; end
      2'd1: begin mul_x = m_dot; mul_y = m_dot[ACC_W-1:HALF_W]; end
      2'd2: begin mul_x = m_ea;  mul_y = m_eb[HALF_W-1:0]; end
      default: begin mul_x = m_ea; mul_y = m_eb[ACC_W-1:HALF_W]; end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // Operands of the current ratio.
  assign num_sel = phase ? PROD_W'(sqs) : dsq;
  assign den_sel = phase ? dsq : eprod;
  assign rem_sh  = {rem[REM_W-2:0], 1'b0};

  // One root digit per cycle.
  assign strial = sres + sbit;
  assign sres_next = (quo >= strial) ? ((sres >> 1) + sbit) : (sres >> 1);

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      phase <= 1'b0;
    end else begin
      // The result register loads from the sequencer or empties on a taken beat.
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            m_ea <= q_data.energy_a;
            m_eb <= q_data.energy_b;
            m_dot <= q_data.shared_dot;
            sqs <= q_data.shared_square_sum;
            phase <= 1'b0;
            cnt <= '0;
            if (q_data.shared_dot == '0 || q_data.energy_a == '0 ||
                q_data.energy_b == '0) begin
              und <= 1'b1;
              sim_hold <= '0;
              bias_hold <= '0;
              state <= S_OUT;
            end else begin
              und <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          unique case (cnt[1:0])
            2'd0: dsq <= PROD_W'(mul_p);
            2'd1: dsq <= dsq + (PROD_W'(mul_p) << HALF_W);
            2'd2: eprod <= PROD_W'(mul_p);
            default: eprod <= eprod + (PROD_W'(mul_p) << HALF_W);
          endcase
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) state <= S_DSET;
        end
        S_DSET: begin
          // A ratio at or above one is capped without dividing.
          if (num_sel >= den_sel) begin
            if (phase) begin
              bias_hold <= RES_W'(1) << FRAC_BITS;
              state <= S_OUT;
            end else begin
              sim_hold <= RES_W'(1) << FRAC_BITS;
              phase <= 1'b1;
            end
          end else begin
            rem <= {1'b0, num_sel};
            quo <= '0;
            cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem_sh >= {1'b0, den_sel}) begin
            rem <= rem_sh - {1'b0, den_sel};
            quo <= {quo[TWO_F-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[TWO_F-2:0], 1'b0};
          end
          if (cnt == CNT_W'(TWO_F - 1)) begin
            cnt <= '0;
            sres <= '0;
            sbit <= TWO_F'(1) << (TWO_F - 2);
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (quo >= strial) quo <= quo - strial;
          sres <= sres_next;
          sbit <= sbit >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            if (phase) begin
              bias_hold <= RES_W'(sres_next);
              state <= S_OUT;
            end else begin
              sim_hold <= RES_W'(sres_next);
              phase <= 1'b1;
              state <= S_DSET;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      similarity <= OUT_W'(sim_hold);
      bias <= OUT_W'(bias_hold);
      undefined <= und;
    end
  end

endmodule
`default_nettype wire

>>> design/spectrum_cosine_dot_bias_top.sv
// Accepts one bin pair per cycle while in_ready is high; a result beat
// follows the last pair of a comparison, computed by the shared bit-serial
// divider and root unit in the back end, which serve the two ratios in turn.
// The back end starts a comparison only when done with the last one; a capped
// ratio or an undefined result skips those units; four may wait in the queue.
// Synchronous active-high reset clears all sums, the queue and the sequencer.
`default_nettype none
module spectrum_cosine_dot_bias_top import scd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IN_W-1:0]  bin_a,
  input  wire logic [IN_W-1:0]  bin_b,
  input  wire logic             last_bin,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      similarity,
  output logic [OUT_W-1:0]      bias,
  output logic                  undefined
);

  logic               push, pop, q_valid;
  sums_t              push_data, q_data;
  logic [Q_CNT_W-1:0] q_count;

  scd_front u_front (
    .clk, .rst, .in_valid, .in_ready, .bin_a, .bin_b, .last_bin,
    .q_count, .push, .push_data
  );

  scd_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .q_valid, .q_data, .q_count
  );

  scd_back u_back (
    .clk, .rst, .q_valid, .q_data, .pop, .out_valid, .out_ready,
    .similarity, .bias, .undefined
  );

endmodule
`default_nettype wire

>>> bench/spectrum_cosine_dot_bias_top_tb.sv
`default_nettype none
module spectrum_cosine_dot_bias_top_tb import scd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    logic            last;
  } bin_pair_t;

  typedef struct {
    logic [OUT_W-1:0] similarity;
    logic [OUT_W-1:0] bias;
    logic             undefined;
  } score_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IN_W-1:0]  bin_a = '0;
  logic [IN_W-1:0]  bin_b = '0;
  logic             last_bin = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] similarity;
  logic [OUT_W-1:0] bias;
  logic             undefined;

  spectrum_cosine_dot_bias_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .bin_a(bin_a), .bin_b(bin_b), .last_bin(last_bin),
    .out_valid(out_valid), .out_ready(out_ready),
    .similarity(similarity), .bias(bias), .undefined(undefined)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bin_pair_t pending_pairs[$];
  score_t    expected_scores[$];
  int        error_count = 0;
  bit        burst_mode = 1'b0;

  // Running sums of the comparison in progress, as the block should hold them.
  logic [ACC_W-1:0] sum_sq_a = '0;
  logic [ACC_W-1:0] sum_sq_b = '0;
  logic [ACC_W-1:0] sum_dot = '0;
  logic [SQS_W-1:0] sum_dot_sq = '0;

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(sqrt(num / den)) capped at 1.0; num is already scaled by 2^(2F).
  function automatic logic [63:0] capped_root(input logic [127:0] num,
                                              input logic [127:0] den);
    logic [127:0] quot;
    if (num >= (den << TWO_F)) return 64'd1 << FRAC_BITS;
    quot = num / den;
    return int_sqrt(quot[63:0]);
  endfunction

  function automatic logic [SQS_W-1:0] sat_add(input logic [SQS_W-1:0] acc,
                                               input logic [SQS_W-1:0] v,
                                               input int width);
    logic [SQS_W:0]   s;
    logic [SQS_W-1:0] top;
    top = (width == SQS_W) ? {SQS_W{1'b1}} : ((SQS_W'(1) << width) - 1);
    s = {1'b0, acc} + {1'b0, v};
    return (s > {1'b0, top}) ? top : s[SQS_W-1:0];
  endfunction

  // Adds one accepted pair to the sums and queues a score on the last pair.
  task automatic accumulate_bin(input bin_pair_t p);
    logic [SQS_W-1:0] prod;
    logic [127:0]     dot_sq;
    logic [127:0]     energy_prod;
    logic [63:0]      sim_v;
    logic [63:0]      bias_v;
    score_t           sc;
    sum_sq_a = ACC_W'(sat_add(SQS_W'(sum_sq_a), SQS_W'(p.a) * p.a, ACC_W));
    sum_sq_b = ACC_W'(sat_add(SQS_W'(sum_sq_b), SQS_W'(p.b) * p.b, ACC_W));
    if (p.a != 0 && p.b != 0) begin
      prod = SQS_W'(p.a) * p.b;
      sum_dot = ACC_W'(sat_add(SQS_W'(sum_dot), prod, ACC_W));
      sum_dot_sq = sat_add(sum_dot_sq, prod * prod, SQS_W);
    end
    if (!p.last) return;
    if (sum_dot == 0 || sum_sq_a == 0 || sum_sq_b == 0) begin
      sc.similarity = '0;
      sc.bias = '0;
      sc.undefined = 1'b1;
    end else begin
      dot_sq = 128'(sum_dot) * 128'(sum_dot);
      energy_prod = 128'(sum_sq_a) * 128'(sum_sq_b);
      sim_v = capped_root(dot_sq << TWO_F, energy_prod);
      bias_v = capped_root(128'(sum_dot_sq) << TWO_F, dot_sq);
      sc.similarity = sim_v[OUT_W-1:0];
      sc.bias = bias_v[OUT_W-1:0];
      sc.undefined = 1'b0;
    end
    expected_scores.push_back(sc);
    sum_sq_a = '0;
    sum_sq_b = '0;
    sum_dot = '0;
    sum_dot_sq = '0;
  endtask

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 14);
  endfunction

  // Driver: presents queued pairs, with a random gap before each beat.
  int        send_gap = 0;
  int        sent_count = 0;
  bin_pair_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_bin(on_bus);
        sent_count++;
        if (sent_count % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          on_bus = pending_pairs.pop_front();
          bin_a <= on_bus.a;
          bin_b <= on_bus.b;
          last_bin <= on_bus.last;
          in_valid <= 1'b1;
          send_gap <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result side at random and checks each accepted beat.
  int     stall_gap = 0;
  score_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $display("ERROR %0t: result beat with nothing expected", $realtime);
          error_count++;
        end else begin
          want = expected_scores.pop_front();
          if (similarity !== want.similarity)
            report_mismatch("similarity", similarity, want.similarity);
          if (bias !== want.bias) report_mismatch("bias", bias, want.bias);
          if (undefined !== want.undefined)
            report_mismatch("undefined", OUT_W'(undefined), OUT_W'(want.undefined));
        end
        stall_gap = draw_gap();
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_pair(input int a, input int b, input bit last);
    bin_pair_t p;
    p.a = IN_W'(a);
    p.b = IN_W'(b);
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  function automatic int pick_bin(input int style);
    case (style)
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4095);
      default: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1;
          2: return 2048;
          default: return 4095;
        endcase
      end
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int queued;
    int len;
    int style;
    int a;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, undefined cases, identical and disjoint spectra.
    add_pair(0, 0, 1);
    add_pair(4095, 4095, 1);
    add_pair(4095, 0, 0);
    add_pair(0, 4095, 1);
    add_pair(1, 1, 1);
    add_pair(1, 4095, 0);
    add_pair(4095, 1, 1);
    add_pair(4095, 4095, 0);
    add_pair(4095, 0, 1);
    add_pair(0, 0, 0);
    add_pair(0, 0, 1);
    add_pair(2048, 1, 0);
    add_pair(1, 2048, 0);
    add_pair(4095, 4095, 0);
    add_pair(0, 4095, 1);
    add_pair(5, 10, 0);
    add_pair(3, 6, 1);
    add_pair(1, 0, 0);
    add_pair(0, 1, 0);
    add_pair(1, 1, 1);

    // Random comparisons of varied length and content.
    queued = 0;
    while (queued < 1030) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(65, 200);
        1, 2, 3: len = $urandom_range(17, 64);
        default: len = $urandom_range(1, 16);
      endcase
      style = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if (style == 4) begin
          a = pick_bin(0);
          add_pair(a, ($urandom_range(0, 4) == 0) ? pick_bin(0) : a, i == len - 1);
        end else begin
          add_pair(pick_bin(style), pick_bin(style), i == len - 1);
        end
      end
      queued += len;
    end

    wait (pending_pairs.size() == 0 && !in_valid && expected_scores.size() == 0);
    repeat (300) @(posedge clk);
    if (expected_scores.size() != 0) begin
      $display("ERROR: %0d results never arrived", expected_scores.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> spectrum_cosine_dot_bias_top.f
design/scd_pkg.sv
design/scd_front.sv
design/scd_queue.sv
design/scd_back.sv
design/spectrum_cosine_dot_bias_top.sv
bench/spectrum_cosine_dot_bias_top_tb.sv
